// ===== hdl/ccse_pkg.sv =====
// Shared types and constants for the cross-correlation shift estimator.
package ccse_pkg;

   localparam int SHIFT_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE    = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_EVAL,
      ST_DRAIN,
      ST_POST
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic eval_start;
      logic sweep;
      logic publish;
      logic restart;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_last;
      logic sweep_done;
      logic pipe_busy;
   } dp_status_type;

endpackage

// ===== hdl/ccse_ctrl.sv =====
// Controller: frame loading, correlation sweep, drain and result handoff.
module ccse_ctrl
   import ccse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && status.frame_last) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.sweep_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_POST;
         end
         ST_POST: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_tready     = 1'b1;
            cmd.load       = req_tvalid;
            cmd.eval_start = req_tvalid && status.frame_last;
         end
         ST_EVAL: begin
            cmd.sweep = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_POST: begin
            cmd.publish = out_free;
            cmd.restart = out_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/ccse_datapath.sv =====
// Datapath: image stores, totals, offset sweep, correlation pipeline, peak tracking.
module ccse_datapath
   import ccse_pkg::*;
#(
   parameter int MAX_SIDE   = 64,
   parameter int PIXEL_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [11:0]           src_pixel,
   input  logic [11:0]           ref_pixel,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [SHIFT_W-1:0]    shift_x,
   output logic [SHIFT_W-1:0]    shift_y
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int AW     = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int TOT_W  = PIXEL_BITS + AW;
   localparam int DEV_W  = CNT_W + PIXEL_BITS + 1;
   localparam int PROD_W = 2 * DEV_W;
   localparam int ACC_W  = PROD_W + AW;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CSR_DATA_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) r = SIDE_W'(1);
      else if (32'(v) > MAX_SIDE) r = SIDE_W'(MAX_SIDE);
      else r = SIDE_W'(v);
      return r;
   endfunction

   // configuration
   logic [CSR_DATA_W-1:0] width_ff, height_ff, grid_ff;
   logic [SIDE_W-1:0]     w, h, g, n;
   logic [CNT_W-1:0]      total;
   logic                  dim_write;

   assign w = clamp_side(width_ff);
   assign h = clamp_side(height_ff);
   assign g = clamp_side(grid_ff);
   always_comb begin
      n = g;
      if (n < w) n = w;
      if (n < h) n = h;
   end
   assign total = CNT_W'(w) * CNT_W'(h);
   assign dim_write = csr_we &&
      (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_DATA_W'(64);
         height_ff <= CSR_DATA_W'(64);
         grid_ff   <= CSR_DATA_W'(64);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            REG_GRID_SIZE:    grid_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // frame loading
   logic [CNT_W-1:0]      count_ff;
   logic [TOT_W-1:0]      src_tot_ff, ref_tot_ff;
   logic [PIXEL_BITS-1:0] src_pix, ref_pix;

   assign src_pix = src_pixel[PIXEL_BITS-1:0];
   assign ref_pix = ref_pixel[PIXEL_BITS-1:0];
   assign status.frame_last = (count_ff + CNT_W'(1)) == total;

   always_ff @(posedge clock) begin
      if (reset || dim_write || cmd.restart) begin
         count_ff   <= '0;
         src_tot_ff <= '0;
         ref_tot_ff <= '0;
      end else if (cmd.load) begin
         count_ff   <= count_ff + CNT_W'(1);
         src_tot_ff <= src_tot_ff + TOT_W'(src_pix);
         ref_tot_ff <= ref_tot_ff + TOT_W'(ref_pix);
      end
   end

   logic [PIXEL_BITS-1:0] src_mem [DEPTH];
   logic [PIXEL_BITS-1:0] ref_mem [DEPTH];
   logic [PIXEL_BITS-1:0] src_rd_ff, ref_rd_ff;
   logic [AW-1:0]         addr_a, addr_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_mem[count_ff[AW-1:0]] <= src_pix;
         ref_mem[count_ff[AW-1:0]] <= ref_pix;
      end
      src_rd_ff <= src_mem[addr_a];
      ref_rd_ff <= ref_mem[addr_b_ff];
   end

   // offset sweep: (ky, kx) outer, (y, x) inner
   logic [SIDE_W-1:0]   x_ff, y_ff, kx_ff, ky_ff;
   logic [SIDE_W:0]     sum_x, sum_y;
   logic [SIDE_W-1:0]   ax, ay;
   logic [2*SIDE_W-1:0] row_a;
   logic                term_ok, pos_first, pos_last, x_end, kx_end, ky_end;

   assign sum_x = {1'b0, x_ff} + {1'b0, kx_ff};
   assign sum_y = {1'b0, y_ff} + {1'b0, ky_ff};
   assign ax = (sum_x >= {1'b0, n}) ? SIDE_W'(sum_x - {1'b0, n}) : SIDE_W'(sum_x);
   assign ay = (sum_y >= {1'b0, n}) ? SIDE_W'(sum_y - {1'b0, n}) : SIDE_W'(sum_y);
   assign row_a = ay * w;
   assign addr_a = AW'(row_a) + AW'(ax);
   assign term_ok = (ax < w) && (ay < h);
   assign x_end = x_ff == w - SIDE_W'(1);
   assign kx_end = kx_ff == n - SIDE_W'(1);
   assign ky_end = ky_ff == n - SIDE_W'(1);
   assign pos_first = (x_ff == '0) && (y_ff == '0);
   assign pos_last = x_end && (y_ff == h - SIDE_W'(1));
   assign status.sweep_done = cmd.sweep && pos_last && kx_end && ky_end;

   always_ff @(posedge clock) begin
      if (reset || cmd.eval_start) begin
         x_ff      <= '0;
         y_ff      <= '0;
         kx_ff     <= '0;
         ky_ff     <= '0;
         addr_b_ff <= '0;
      end else if (cmd.sweep) begin
         if (pos_last) begin
            x_ff      <= '0;
            y_ff      <= '0;
            addr_b_ff <= '0;
            if (kx_end) begin
               kx_ff <= '0;
               ky_ff <= ky_ff + SIDE_W'(1);
            end else begin
               kx_ff <= kx_ff + SIDE_W'(1);
            end
         end else begin
            addr_b_ff <= addr_b_ff + AW'(1);
            if (x_end) begin
               x_ff <= '0;
               y_ff <= y_ff + SIDE_W'(1);
            end else begin
               x_ff <= x_ff + SIDE_W'(1);
            end
         end
      end
   end

   // correlation pipeline: read, deviation, product, accumulate
   logic s1_live_ff, s2_live_ff, s3_live_ff, s4_live_ff;
   logic s1_term_ff, s2_term_ff, s3_term_ff;
   logic s1_first_ff, s2_first_ff, s3_first_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;
   logic [SIDE_W-1:0] s1_kx_ff, s2_kx_ff, s3_kx_ff, s4_kx_ff;
   logic [SIDE_W-1:0] s1_ky_ff, s2_ky_ff, s3_ky_ff, s4_ky_ff;
   logic [CNT_W+PIXEL_BITS-1:0] ps_a, ps_b;
   logic signed [DEV_W-1:0]  dev_a_ff, dev_b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, best_ff;
   logic [SIDE_W-1:0]        best_kx_ff, best_ky_ff;

   assign ps_a = count_ff * src_rd_ff;
   assign ps_b = count_ff * ref_rd_ff;
   assign status.pipe_busy = s1_live_ff || s2_live_ff || s3_live_ff || s4_live_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_live_ff <= 1'b0;
         s2_live_ff <= 1'b0;
         s3_live_ff <= 1'b0;
         s4_live_ff <= 1'b0;
      end else begin
         s1_live_ff <= cmd.sweep;
         s2_live_ff <= s1_live_ff;
         s3_live_ff <= s2_live_ff;
         s4_live_ff <= s3_live_ff;
      end
   end

   always_comb begin
      acc_in = s3_first_ff ? '0 : acc_ff;
      if (s3_term_ff) acc_in = acc_in + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      s1_term_ff  <= term_ok;
      s1_first_ff <= pos_first;
      s1_last_ff  <= pos_last;
      s1_kx_ff    <= kx_ff;
      s1_ky_ff    <= ky_ff;

      s2_term_ff  <= s1_term_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_kx_ff    <= s1_kx_ff;
      s2_ky_ff    <= s1_ky_ff;
      dev_a_ff    <= $signed({1'b0, ps_a}) - $signed(DEV_W'(src_tot_ff));
      dev_b_ff    <= $signed({1'b0, ps_b}) - $signed(DEV_W'(ref_tot_ff));

      s3_term_ff  <= s2_term_ff;
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_kx_ff    <= s2_kx_ff;
      s3_ky_ff    <= s2_ky_ff;
      prod_ff     <= dev_a_ff * dev_b_ff;

      s4_last_ff  <= s3_last_ff;
      s4_kx_ff    <= s3_kx_ff;
      s4_ky_ff    <= s3_ky_ff;
      if (s3_live_ff) acc_ff <= acc_in;
   end

   // first maximum in raster order wins: strict compare
   always_ff @(posedge clock) begin
      if (reset || cmd.eval_start) begin
         best_ff    <= {1'b1, {(ACC_W-1){1'b0}}};
         best_kx_ff <= '0;
         best_ky_ff <= '0;
      end else if (s4_live_ff && s4_last_ff && (acc_ff > best_ff)) begin
         best_ff    <= acc_ff;
         best_kx_ff <= s4_kx_ff;
         best_ky_ff <= s4_ky_ff;
      end
   end

   // wrap peak index to signed offset and negate
   logic [SIDE_W-1:0]        half;
   logic signed [SIDE_W:0]   off_x, off_y, neg_x, neg_y;
   logic [SHIFT_W-1:0]       shift_x_ff, shift_y_ff;

   assign half = n >> 1;
   assign off_x = (best_kx_ff > half) ? $signed({1'b0, best_kx_ff}) - $signed({1'b0, n})
                                      : $signed({1'b0, best_kx_ff});
   assign off_y = (best_ky_ff > half) ? $signed({1'b0, best_ky_ff}) - $signed({1'b0, n})
                                      : $signed({1'b0, best_ky_ff});
   assign neg_x = -off_x;
   assign neg_y = -off_y;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         shift_x_ff <= SHIFT_W'(neg_x);
         shift_y_ff <= SHIFT_W'(neg_y);
      end
   end

   assign shift_x = shift_x_ff;
   assign shift_y = shift_y_ff;

   a_no_load_in_sweep: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.sweep))
      else $error("pixel write during correlation sweep");

   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !status.pipe_busy && !cmd.sweep)
      else $error("result published while pipeline busy");

   a_full_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.eval_start |=> count_ff == total)
      else $error("sweep started without a full frame");

endmodule

// ===== hdl/cross_correlation_shift_estimator.sv =====
// After the last pixel beat the block sweeps all N x N offsets over every W x H pixel,
//   then drains the pipeline and hands off before rsp_tvalid rises (N = max of grid, W, H).
// Throughput: one pixel beat per cycle while loading; the sweep through the shared
//   multiply-accumulate unit, one term per cycle, sets the frame rate.
// Reset: synchronous, active high; registers return to 64 x 64 with grid 64, frame empty.
module cross_correlation_shift_estimator
   import ccse_pkg::*;
#(
   parameter int MAX_SIDE   = 64,
   parameter int PIXEL_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // source_pixel[11:0], reference_pixel[23:12]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // shift_x[6:0], shift_y[13:7], zero pad
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [SHIFT_W-1:0] shift_x, shift_y;

   ccse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ccse_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .src_pixel (req_tdata[11:0]),
      .ref_pixel (req_tdata[23:12]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .shift_x   (shift_x),
      .shift_y   (shift_y)
   );

   assign rsp_tdata = {2'b00, shift_y, shift_x};

endmodule

// ===== dv/tb_cross_correlation_shift_estimator.sv =====
// Self-checking testbench for the cross-correlation shift estimator.
module tb_cross_correlation_shift_estimator;
   import ccse_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE_MAX = 64;
   localparam int DEPTH = SIDE_MAX * SIDE_MAX;
   localparam int SETTLE_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 1500000;

   typedef struct {
      logic signed [SHIFT_W-1:0] dx;
      logic signed [SHIFT_W-1:0] dy;
   } shift_type;

   typedef struct {
      bit                  is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] val;
      logic [11:0]         src;
      logic [11:0]         ref_pix;
      bit                  typed;
      shift_type           want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cross_correlation_shift_estimator dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // shadow of the block's registers and frame state
   logic [6:0] width_reg, height_reg, grid_reg;
   logic [11:0] src_mem[DEPTH];
   logic [11:0] ref_mem[DEPTH];
   int unsigned src_sum, ref_sum, loaded;
   longint src_dev[DEPTH];
   longint ref_dev[DEPTH];

   shift_type shift_q[$];
   bit typed_pending = 0;
   shift_type typed_want;

   int errors = 0;
   int pixels_sent = 0;
   int shifts_seen = 0;
   int frames_started = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   function automatic int unsigned clamp_side(logic [6:0] v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
   endfunction

   function automatic shift_type find_shift(int unsigned w, int unsigned h);
      int unsigned n, p, ax, ay, best_kx, best_ky;
      int px, py, half;
      longint acc, best;
      shift_type res;
      n = clamp_side(grid_reg);
      if (n < w) n = w;
      if (n < h) n = h;
      p = w * h;
      for (int i = 0; i < p; i++) begin
         src_dev[i] = longint'(p) * src_mem[i] - longint'(src_sum);
         ref_dev[i] = longint'(p) * ref_mem[i] - longint'(ref_sum);
      end
      best = -(longint'(1) << 61);
      best_kx = 0;
      best_ky = 0;
      for (int ky = 0; ky < n; ky++) begin
         for (int kx = 0; kx < n; kx++) begin
            acc = 0;
            for (int y = 0; y < h; y++) begin
               ay = (y + ky) % n;
               if (ay < h) begin
                  for (int x = 0; x < w; x++) begin
                     ax = (x + kx) % n;
                     if (ax < w) acc += src_dev[ay * w + ax] * ref_dev[y * w + x];
                  end
               end
            end
            if (acc > best) begin
               best = acc;
               best_kx = kx;
               best_ky = ky;
            end
         end
      end
      half = n / 2;
      px = best_kx;
      py = best_ky;
      if (px > half) px -= n;
      if (py > half) py -= n;
      res.dx = -px;
      res.dy = -py;
      return res;
   endfunction

   // track configuration and pixel beats as the block sees them
   always @(posedge clock) begin
      int unsigned w, h;
      shift_type s;
      if (reset) begin
         width_reg <= 7'd64;
         height_reg <= 7'd64;
         grid_reg <= 7'd64;
         src_sum = 0;
         ref_sum = 0;
         loaded = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg <= csr_wdata;
                  loaded = 0; src_sum = 0; ref_sum = 0;
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg <= csr_wdata;
                  loaded = 0; src_sum = 0; ref_sum = 0;
               end
               REG_GRID_SIZE: grid_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            w = clamp_side(width_reg);
            h = clamp_side(height_reg);
            if (loaded >= w * h) begin
               loaded = 0; src_sum = 0; ref_sum = 0;
            end
            src_mem[loaded] = req_tdata[11:0];
            ref_mem[loaded] = req_tdata[23:12];
            src_sum += req_tdata[11:0];
            ref_sum += req_tdata[23:12];
            loaded++;
            if (loaded == w * h) begin
               s = find_shift(w, h);
               if (typed_pending) begin
                  typed_pending = 0;
                  if (s.dx !== typed_want.dx || s.dy !== typed_want.dy) begin
                     $display("%0t: table shift mismatch expected %0d,%0d actual %0d,%0d",
                              $time, typed_want.dx, typed_want.dy, s.dx, s.dy);
                     errors++;
                  end
               end
               shift_q = {shift_q, s};
               loaded = 0; src_sum = 0; ref_sum = 0;
            end
         end
      end
   end

   // result beats against the oldest predicted shift
   always @(posedge clock) begin
      shift_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         shifts_seen++;
         if (shift_q.size() == 0) begin
            $display("%0t: unexpected result beat actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = shift_q.pop_front();
            if (rsp_tdata[6:0] !== want.dx || rsp_tdata[13:7] !== want.dy) begin
               $display("%0t: shift mismatch expected x=%0d y=%0d actual x=%0d y=%0d",
                        $time, want.dx, want.dy, $signed(rsp_tdata[6:0]),
                        $signed(rsp_tdata[13:7]));
               errors++;
            end
            if (rsp_tdata[15:14] !== 2'b00) begin
               $display("%0t: pad bits expected 0 actual %b", $time, rsp_tdata[15:14]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // receiver stalls on a rotating pattern that changes now and then
   logic [7:0] stall_pat = 8'hFF;
   int unsigned stall_phase = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pat <= 8'hFF;
            1: stall_pat <= 8'h01;
            default: stall_pat <= 8'($urandom_range(1, 255));
         endcase
      end
      rsp_tready <= stall_pat[stall_phase % 8];
      stall_phase <= stall_phase + 1;
   end

   // one write beat, then csr_we is dropped and held low before anything else is driven
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 0;
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 0;
      wait (shift_q.size() == 0);
      @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_pixel(logic [11:0] s, logic [11:0] r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {r, s};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      @(negedge clock);
   endtask

   stim_row_type table_rows[$];
   logic [11:0] frame_src[DEPTH];
   logic [11:0] frame_ref[DEPTH];

   task automatic make_frame(int unsigned w, int unsigned h);
      int unsigned mode, sx, sy;
      mode = $urandom_range(0, 9);
      sx = $urandom_range(0, w - 1);
      sy = $urandom_range(0, h - 1);
      for (int i = 0; i < w * h; i++) begin
         case (mode)
            0: frame_src[i] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            1: frame_src[i] = 12'h5A5;
            default: frame_src[i] = 12'($urandom);
         endcase
      end
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) begin
            if (mode >= 5)   // reference is a cyclic copy of the source
               frame_ref[y * w + x] = frame_src[((y + sy) % h) * w + (x + sx) % w];
            else if (mode == 0)
               frame_ref[y * w + x] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            else
               frame_ref[y * w + x] = 12'($urandom);
         end
   endtask

   initial begin
      int unsigned w, h, g, cut;
      table_rows = '{
         '{1, REG_IMAGE_WIDTH, 0, 0, 0, 0, '{0, 0}},
         '{1, REG_IMAGE_HEIGHT, 1, 0, 0, 0, '{0, 0}},
         '{1, REG_GRID_SIZE, 0, 0, 0, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'h000, 1, '{0, 0}},
         '{1, REG_IMAGE_WIDTH, 2, 0, 0, 0, '{0, 0}},
         '{1, REG_IMAGE_HEIGHT, 2, 0, 0, 0, '{0, 0}},
         '{1, REG_GRID_SIZE, 3, 0, 0, 0, '{0, 0}},
         '{0, 0, 0, 12'h000, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'h000, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'h000, 12'h000, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'hFFF, 1, '{0, 0}},
         '{1, REG_IMAGE_WIDTH, 3, 0, 0, 0, '{0, 0}},
         '{1, REG_IMAGE_HEIGHT, 2, 0, 0, 0, '{0, 0}},
         '{1, REG_GRID_SIZE, 2, 0, 0, 0, '{0, 0}},
         '{0, 0, 0, 12'd1, 12'd2, 0, '{0, 0}},
         '{0, 0, 0, 12'd3, 12'd4, 0, '{0, 0}},
         '{1, REG_IMAGE_WIDTH, 3, 0, 0, 0, '{0, 0}},  // restarts the partial frame
         '{0, 0, 0, 12'hFFF, 12'd10, 0, '{0, 0}},
         '{0, 0, 0, 12'h000, 12'hFFF, 0, '{0, 0}},
         '{0, 0, 0, 12'd100, 12'd200, 0, '{0, 0}},
         '{0, 0, 0, 12'hFFF, 12'h000, 0, '{0, 0}},
         '{0, 0, 0, 12'd7, 12'd7, 0, '{0, 0}},
         '{0, 0, 0, 12'h800, 12'd1, 0, '{0, 0}}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].is_csr) begin
            wait_quiet();
            write_reg(table_rows[i].idx, table_rows[i].val);
         end else begin
            if (table_rows[i].typed) begin
               typed_want = table_rows[i].want;
               typed_pending = 1;
            end
            send_pixel(table_rows[i].src, table_rows[i].ref_pix);
         end
      end

      while (pixels_sent < 780) begin
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 6);
         g = $urandom_range(0, 9);
         wait_quiet();
         write_reg(REG_GRID_SIZE, 7'(g));
         write_reg(REG_IMAGE_HEIGHT, 7'(h));
         write_reg(REG_IMAGE_WIDTH, 7'(w));
         if ($urandom_range(0, 2) == 0) write_reg(2'd3, 7'($urandom));  // unused index
         make_frame(w, h);
         frames_started++;
         if ($urandom_range(0, 7) == 0 && w * h > 1) begin
            // broken frame: abandoned by a dimension write
            cut = $urandom_range(1, w * h - 1);
            for (int i = 0; i < cut; i++) send_pixel(frame_src[i], frame_ref[i]);
            write_reg(REG_IMAGE_WIDTH, 7'(w));
         end
         for (int i = 0; i < w * h; i++) send_pixel(frame_src[i], frame_ref[i]);
      end

      // widest frame: out-of-range values clamp to 64 wide, 1 high, grid 64
      wait_quiet();
      write_reg(REG_IMAGE_WIDTH, 7'd127);
      write_reg(REG_IMAGE_HEIGHT, 7'd0);
      write_reg(REG_GRID_SIZE, 7'd127);
      make_frame(64, 1);
      for (int i = 0; i < 64; i++) send_pixel(frame_src[i], frame_ref[i]);
      req_tvalid <= 0;

      wait (shift_q.size() == 0);
      repeat (SETTLE_CYCLES * 2) @(negedge clock);
      $display("Ran %0d pixel beats over %0d random frames plus directed cases;",
               pixels_sent, frames_started);
      $display("checked %0d shift results, %0d mismatches.", shifts_seen, errors);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ccse_pkg.sv
hdl/ccse_ctrl.sv
hdl/ccse_datapath.sv
hdl/cross_correlation_shift_estimator.sv
dv/tb_cross_correlation_shift_estimator.sv
